// ===== src/aesd_pkg.sv =====
// Package for the AES-128 block decrypt unit: beat types, controller/datapath
// command and status structs, inverse S-box table and InvMixColumns helpers.
// No dependencies.
package aesd_pkg;

    localparam int ROUNDS    = 10;
    localparam int KEY_SLOTS = ROUNDS + 1;
    localparam int KIDX_W    = $clog2(KEY_SLOTS);
    localparam int ROUND_W   = $clog2(ROUNDS + 1);

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [3:0]  key_index;
        logic [63:0] word_hi;
        logic [63:0] word_lo;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] plain_hi;
        logic [63:0] plain_lo;
    } out_beat_t;

    typedef struct packed {
        logic               key_wr;
        logic [KIDX_W-1:0]  key_wr_idx;
        logic               key_rd;
        logic [KIDX_W-1:0]  key_rd_idx;
        logic               load_block;
        logic               do_init;
        logic               do_round;
        logic               last_round;
        logic               out_load;
        logic               out_clear;
    } dp_cmd_t;

    typedef struct packed {
        logic out_valid;
    } dp_status_t;

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] m9(input logic [7:0] a);
        logic [7:0] a8;
        a8 = xt(xt(xt(a)));
        return a8 ^ a;
    endfunction

    function automatic logic [7:0] m11(input logic [7:0] a);
        logic [7:0] a2, a8;
        a2 = xt(a);
        a8 = xt(xt(a2));
        return a8 ^ a2 ^ a;
    endfunction

    function automatic logic [7:0] m13(input logic [7:0] a);
        logic [7:0] a4, a8;
        a4 = xt(xt(a));
        a8 = xt(a4);
        return a8 ^ a4 ^ a;
    endfunction

    function automatic logic [7:0] m14(input logic [7:0] a);
        logic [7:0] a2, a4, a8;
        a2 = xt(a);
        a4 = xt(a2);
        a8 = xt(a4);
        return a8 ^ a4 ^ a2;
    endfunction

endpackage

// ===== src/aesd_datapath.sv =====
// Datapath for the AES-128 block decrypt unit: round key memory, state
// register, one inverse round per cycle while do_round is set, output register. Uses aesd_pkg.
module aesd_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  aesd_pkg::in_beat_t  in_beat,
    input  aesd_pkg::dp_cmd_t   cmd,
    output aesd_pkg::dp_status_t status,
    output aesd_pkg::out_beat_t out_beat
);

    logic [127:0] key_mem [aesd_pkg::KEY_SLOTS];
    logic [127:0] key_q_reg;
    logic [127:0] state_reg;
    logic [127:0] state_next;
    logic [127:0] sub_w;
    logic [127:0] ark_w;
    logic [127:0] mix_w;
    logic         out_valid_reg;
    aesd_pkg::out_beat_t out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.key_wr) begin
            key_mem[cmd.key_wr_idx] <= {in_beat.word_hi, in_beat.word_lo};
        end
        if (cmd.key_rd) begin
            key_q_reg <= key_mem[cmd.key_rd_idx];
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sub_w[127-8*(4*c+r) -: 8] =
                    aesd_pkg::INV_SBOX[state_reg[127-8*(4*((c-r+4)%4)+r) -: 8]];
            end
        end
        ark_w = sub_w ^ key_q_reg;
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3;
            a0 = ark_w[127-32*c -: 8];
            a1 = ark_w[119-32*c -: 8];
            a2 = ark_w[111-32*c -: 8];
            a3 = ark_w[103-32*c -: 8];
            mix_w[127-32*c -: 8] = aesd_pkg::m14(a0) ^ aesd_pkg::m11(a1)
                                 ^ aesd_pkg::m13(a2) ^ aesd_pkg::m9(a3);
            mix_w[119-32*c -: 8] = aesd_pkg::m9(a0) ^ aesd_pkg::m14(a1)
                                 ^ aesd_pkg::m11(a2) ^ aesd_pkg::m13(a3);
            mix_w[111-32*c -: 8] = aesd_pkg::m13(a0) ^ aesd_pkg::m9(a1)
                                 ^ aesd_pkg::m14(a2) ^ aesd_pkg::m11(a3);
            mix_w[103-32*c -: 8] = aesd_pkg::m11(a0) ^ aesd_pkg::m13(a1)
                                 ^ aesd_pkg::m9(a2) ^ aesd_pkg::m14(a3);
        end
        state_next = state_reg;
        if (cmd.load_block) begin
            state_next = {in_beat.word_hi, in_beat.word_lo};
        end else if (cmd.do_init) begin
            state_next = state_reg ^ key_q_reg;
        end else if (cmd.do_round) begin
            state_next = cmd.last_round ? ark_w : mix_w;
        end
    end

    always_ff @(posedge aclk) begin
        state_reg <= state_next;
        if (cmd.out_load) begin
            out_reg <= {ark_w[127:64], ark_w[63:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (cmd.out_clear) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_valid = out_valid_reg;
    assign out_beat         = out_reg;

endmodule

// ===== src/aesd_ctrl.sv =====
// Controller for the AES-128 block decrypt unit: sequences key reads and
// rounds, drives the input handshake. Uses aesd_pkg.
module aesd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  aesd_pkg::in_beat_t   in_beat,
    input  logic                 m_ready,
    input  aesd_pkg::dp_status_t status,
    output aesd_pkg::dp_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_INIT  = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [aesd_pkg::ROUND_W-1:0]  round_reg, round_next;
    logic                          s_fire;
    logic                          out_free;

    assign out_free = !status.out_valid || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        round_next     = round_reg;
        cmd            = '0;
        cmd.out_clear  = m_ready;
        cmd.key_wr_idx = in_beat.key_index[aesd_pkg::KIDX_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (in_beat.mode == aesd_pkg::MODE_LOAD) begin
                        cmd.key_wr = (in_beat.key_index <= 4'(aesd_pkg::ROUNDS));
                    end else begin
                        cmd.load_block = 1'b1;
                        cmd.key_rd     = 1'b1;
                        cmd.key_rd_idx = aesd_pkg::KIDX_W'(aesd_pkg::ROUNDS);
                        state_next     = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                cmd.do_init    = 1'b1;
                cmd.key_rd     = 1'b1;
                cmd.key_rd_idx = aesd_pkg::KIDX_W'(aesd_pkg::ROUNDS - 1);
                round_next     = aesd_pkg::ROUND_W'(aesd_pkg::ROUNDS - 1);
                state_next     = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.last_round = (round_reg == '0);
                if (cmd.last_round) begin
                    if (out_free) begin
                        cmd.do_round = 1'b1;
                        cmd.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.do_round   = 1'b1;
                    cmd.key_rd     = 1'b1;
                    cmd.key_rd_idx = aesd_pkg::KIDX_W'(round_reg - 1'b1);
                    round_next     = round_reg - 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

endmodule

// ===== src/aes128_block_decrypt_unit.sv =====
// AES-128 inverse cipher: top level joining controller and datapath.
// Uses aesd_pkg, aesd_ctrl, aesd_datapath.
//
// Input channel s_valid/s_ready/s_data carries one beat per item. Mode 0
// writes a round key (slots 0..10; higher key_index is dropped) and yields
// no result. Mode 1 decrypts one block; the plaintext leaves on
// m_valid/m_ready/m_data.
// Sequence: a decrypt beat accepted in idle loads the block, the INIT state
// adds key 10 and the ROUND state runs the 10 rounds, one per cycle through
// the round unit fed by the one-read round key memory; the last round waits
// for a free output register, then registers the result, and m_valid is high
// from then on. A new beat is taken only back in idle, so a block finishes
// before the next beat is accepted; key loads are taken in idle as well.
// The result sits in an output register, so the next beat is accepted while
// the receiver stalls; a second result waits in the last round until the
// register frees.
// Reset (aresetn low, synchronous) clears control state and m_valid; the
// round key store is not cleared and must be loaded before use.
module aes128_block_decrypt_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  aesd_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output aesd_pkg::out_beat_t m_data
);

    aesd_pkg::dp_cmd_t    cmd;
    aesd_pkg::dp_status_t status;

    aesd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_beat (s_data),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    aesd_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_beat  (s_data),
        .cmd      (cmd),
        .status   (status),
        .out_beat (m_data)
    );

    assign m_valid = status.out_valid;

endmodule

// ===== test/tb_aes128_block_decrypt_unit.sv =====
// Testbench for aes128_block_decrypt_unit: key loads and block decrypts, with
// plaintext checked against an in-bench AES-128 inverse cipher.
// Depends on aesd_pkg and the aes128_block_decrypt_unit RTL.
module tb_aes128_block_decrypt_unit;

    localparam int NUM_RANDOM  = 1880;
    localparam int QUIET_AFTER = 1600;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    aesd_pkg::in_beat_t  s_data;
    logic                m_valid;
    logic                m_ready;
    aesd_pkg::out_beat_t m_data;

    aes128_block_decrypt_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    typedef struct {
        aesd_pkg::in_beat_t  beat;
        logic                typed;
        aesd_pkg::out_beat_t plain;
    } stim_row_t;

    logic [7:0]          inv_sub_lut [256];
    logic [63:0]         key_hi_store [aesd_pkg::KEY_SLOTS];
    logic [63:0]         key_lo_store [aesd_pkg::KEY_SLOTS];
    aesd_pkg::out_beat_t expected_plain [$];
    int                  fail_count = 0;
    int                  cycle_count = 0;
    logic                quiet;
    logic                hold_req;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[0]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic logic [7:0] inv_sub_byte(input logic [7:0] x);
        logic [7:0] y, r, base;
        y = {x[6:0], x[7]} ^ {x[4:0], x[7:5]} ^ {x[1:0], x[7:2]} ^ 8'h05;
        r = 8'h01;
        base = y;
        for (int e = 0; e < 8; e++) begin
            if (e != 0) r = gf_mult(r, base);
            base = gf_mult(base, base);
        end
        return r;
    endfunction

    function automatic aesd_pkg::out_beat_t inv_cipher(input logic [63:0] hi,
                                                       input logic [63:0] lo);
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] a0, a1, a2, a3;
        aesd_pkg::out_beat_t res;
        for (int i = 0; i < 8; i++) begin
            st[i]     = hi[(7-i)*8 +: 8] ^ key_hi_store[aesd_pkg::ROUNDS][(7-i)*8 +: 8];
            st[i + 8] = lo[(7-i)*8 +: 8] ^ key_lo_store[aesd_pkg::ROUNDS][(7-i)*8 +: 8];
        end
        for (int rnd = aesd_pkg::ROUNDS - 1; rnd >= 0; rnd--) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tmp[4*c + r] = inv_sub_lut[st[4*((c - r + 4) % 4) + r]];
            for (int i = 0; i < 8; i++) begin
                st[i]     = tmp[i] ^ key_hi_store[rnd][(7-i)*8 +: 8];
                st[i + 8] = tmp[i + 8] ^ key_lo_store[rnd][(7-i)*8 +: 8];
            end
            if (rnd != 0) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                    st[4*c]   = gf_mult(a0,14) ^ gf_mult(a1,11) ^ gf_mult(a2,13) ^ gf_mult(a3,9);
                    st[4*c+1] = gf_mult(a0,9) ^ gf_mult(a1,14) ^ gf_mult(a2,11) ^ gf_mult(a3,13);
                    st[4*c+2] = gf_mult(a0,13) ^ gf_mult(a1,9) ^ gf_mult(a2,14) ^ gf_mult(a3,11);
                    st[4*c+3] = gf_mult(a0,11) ^ gf_mult(a1,13) ^ gf_mult(a2,9) ^ gf_mult(a3,14);
                end
            end
        end
        for (int i = 0; i < 8; i++) begin
            res.plain_hi[(7-i)*8 +: 8] = st[i];
            res.plain_lo[(7-i)*8 +: 8] = st[i + 8];
        end
        return res;
    endfunction

    // Update the key store or queue the plaintext for one accepted beat.
    function automatic void absorb_beat(input aesd_pkg::in_beat_t b);
        if (b.mode == aesd_pkg::MODE_LOAD) begin
            if (b.key_index < aesd_pkg::KEY_SLOTS) begin
                key_hi_store[b.key_index] = b.word_hi;
                key_lo_store[b.key_index] = b.word_lo;
            end
        end else begin
            expected_plain.push_back(inv_cipher(b.word_hi, b.word_lo));
        end
    endfunction

    task automatic send_beat(input aesd_pkg::in_beat_t b);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        absorb_beat(b);
        @(negedge aclk);
    endtask

    function automatic aesd_pkg::in_beat_t random_beat();
        aesd_pkg::in_beat_t b;
        int pick;
        pick = $urandom_range(0, 99);
        b.word_hi   = {$urandom, $urandom};
        b.word_lo   = {$urandom, $urandom};
        b.key_index = 4'($urandom_range(0, 15));
        if (pick < 80) begin
            b.mode = aesd_pkg::MODE_DECRYPT;
        end else if (pick < 95) begin
            b.mode = aesd_pkg::MODE_LOAD;
            b.key_index = 4'($urandom_range(0, aesd_pkg::KEY_SLOTS - 1));
        end else begin
            b.mode = aesd_pkg::MODE_LOAD;
            b.key_index = 4'($urandom_range(aesd_pkg::KEY_SLOTS, 15));
        end
        return b;
    endfunction

    always @(posedge aclk) begin
        aesd_pkg::out_beat_t want;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_plain.size() == 0) begin
                $error("unexpected result beat: plain_hi %h plain_lo %h",
                       m_data.plain_hi, m_data.plain_lo);
                fail_count++;
            end else begin
                want = expected_plain.pop_front();
                if (m_data.plain_hi !== want.plain_hi) begin
                    $error("plain_hi: expected %h, got %h", want.plain_hi, m_data.plain_hi);
                    fail_count++;
                end
                if (m_data.plain_lo !== want.plain_lo) begin
                    $error("plain_lo: expected %h, got %h", want.plain_lo, m_data.plain_lo);
                    fail_count++;
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("aes128_block_decrypt_unit test failed");
            $finish;
        end
    end

    initial begin
        int   burst;
        logic hold_done;
        hold_done = 1'b0;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 10);
                m_ready <= 1'b0;
                repeat (burst) @(negedge aclk);
            end else begin
                burst = $urandom_range(1, 20);
                m_ready <= 1'b1;
                repeat (burst) @(negedge aclk);
            end
        end
    end

    initial begin
        stim_row_t          rows [$];
        stim_row_t          row;
        aesd_pkg::in_beat_t b;
        int                 waited;
        quiet    = 1'b0;
        hold_req = 1'b0;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        for (int i = 0; i < 256; i++) inv_sub_lut[i] = inv_sub_byte(8'(i));
        for (int i = 0; i < aesd_pkg::KEY_SLOTS; i++) begin
            key_hi_store[i] = '0;
            key_lo_store[i] = '0;
        end

        for (int i = 0; i < aesd_pkg::KEY_SLOTS; i++) begin
            row.typed = 1'b0;
            row.plain = '0;
            row.beat.mode      = aesd_pkg::MODE_LOAD;
            row.beat.key_index = 4'(i);
            row.beat.word_hi   = (i == 0) ? 64'h0 :
                                 (i == aesd_pkg::ROUNDS) ? '1 : {8{8'(i * 17)}};
            row.beat.word_lo   = (i == 0) ? 64'h0 :
                                 (i == aesd_pkg::ROUNDS) ? '1 : {8{8'(~(i * 29))}};
            rows.push_back(row);
        end
        row.beat = '{aesd_pkg::MODE_LOAD, 4'hf, '1, '1};
        rows.push_back(row);
        row.beat = '{aesd_pkg::MODE_LOAD, 4'(aesd_pkg::KEY_SLOTS),
                     64'h0123456789abcdef, 64'hfedcba9876543210};
        rows.push_back(row);
        row.beat = '{aesd_pkg::MODE_DECRYPT, 4'h0, 64'h0, 64'h0};
        rows.push_back(row);
        row.beat = '{aesd_pkg::MODE_DECRYPT, 4'hf, '1, '1};
        rows.push_back(row);
        row.beat = '{aesd_pkg::MODE_DECRYPT, 4'h5, {8{8'haa}}, {8{8'h55}}};
        rows.push_back(row);
        row.beat = '{aesd_pkg::MODE_DECRYPT, 4'ha, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a};
        rows.push_back(row);
        row.beat = '{aesd_pkg::MODE_LOAD, 4'h0, '1, 64'h0};
        rows.push_back(row);
        row.beat = '{aesd_pkg::MODE_DECRYPT, 4'h0, 64'h8000000000000000, 64'h1};
        rows.push_back(row);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i]) begin
            if (rows[i].typed) expected_plain.push_back(rows[i].plain);
            send_beat(rows[i].beat);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == HOLD_AT) hold_req = 1'b1;
            if (n == QUIET_AFTER) quiet = 1'b1;
            b = random_beat();
            send_beat(b);
        end
        s_valid <= 1'b0;

        while (expected_plain.size() != 0) @(negedge aclk);
        waited = 0;
        while (waited < 40) begin
            @(negedge aclk);
            waited++;
        end
        if (fail_count == 0) begin
            $display("aes128_block_decrypt_unit test passed");
        end else begin
            $display("aes128_block_decrypt_unit test failed");
        end
        $finish;
    end
endmodule
